// ===== sv/asl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_pkg
// shared constants, register codes and item types of the slew limiter
// ----------------------------------------------------------------------------
package asl_pkg;

    localparam int AXES        = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int AXIS_W      = 3;
    localparam int AXIS_IDX_W  = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int REPORT_W    = 13;
    localparam int DZ_W        = 12;
    localparam int CNT_W       = 8;
    localparam int ACT_W       = 7;
    localparam int STEP_W      = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    // working width for signed differences and candidates
    localparam int CALC_W = ((SAMPLE_BITS > REPORT_W) ? SAMPLE_BITS : REPORT_W) + 3;

    localparam logic [REPORT_W-1:0] CENTER_VALUE = REPORT_W'(2050);
    localparam logic [REPORT_W-1:0] REPORT_LIMIT = REPORT_W'(4096);

    localparam logic [DZ_W-1:0]         DZ_RESET     = DZ_W'(50);
    localparam logic signed [CNT_W-1:0] STATIC_RESET = -CNT_W'(10);
    localparam logic [ACT_W-1:0]        ACT_RESET    = ACT_W'(5);
    localparam logic [STEP_W-1:0]       STEP_RESET   = STEP_W'(100);

    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND    = 2'd0,
        CFG_STATIC_THR  = 2'd1,
        CFG_ACTIVE_THR  = 2'd2,
        CFG_MAX_STEP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DZ_W-1:0]         deadband;
        logic signed [CNT_W-1:0] static_threshold;
        logic [ACT_W-1:0]        active_threshold;
        logic [STEP_W-1:0]       max_step;
    } t_cfg;

    typedef struct packed {
        logic [AXIS_W-1:0]      axis;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [AXIS_W-1:0]   axis_out;
        logic [REPORT_W-1:0] report;
        logic                moving;
    } t_out_item;

endpackage

// ===== sv/asl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl stream interfaces
// sample, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface asl_in_if import asl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [AXIS_W-1:0]      axis;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output axis, output sample, input ready);
    modport sink   (input valid, input axis, input sample, output ready);
endinterface

interface asl_out_if import asl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [AXIS_W-1:0]   axis_out;
    logic [REPORT_W-1:0] report;
    logic                moving;

    modport source (output valid, output axis_out, output report, output moving, input ready);
    modport sink   (input valid, input axis_out, input report, input moving, output ready);
endinterface

interface asl_cfg_if import asl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/asl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
module asl_cfg_regs import asl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    output logic                  o_wr_ready,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_DEADBAND:   n_cfg.deadband         = i_wr_data[DZ_W-1:0];
                CFG_STATIC_THR: n_cfg.static_threshold = signed'(i_wr_data[CNT_W-1:0]);
                CFG_ACTIVE_THR: n_cfg.active_threshold = i_wr_data[ACT_W-1:0];
                CFG_MAX_STEP:   n_cfg.max_step         = i_wr_data[STEP_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband         <= DZ_RESET;
            r_cfg.static_threshold <= STATIC_RESET;
            r_cfg.active_threshold <= ACT_RESET;
            r_cfg.max_step         <= STEP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/asl_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_in_reg
// input register stage; refills in the same cycle it hands its item on
// ----------------------------------------------------------------------------
module asl_in_reg import asl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (r_valid && !i_advance) || i_valid;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/asl_cond.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_cond
// per-axis state and the activity / slew update for one sample
// ----------------------------------------------------------------------------
module asl_cond import asl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic [REPORT_W-1:0]     r_last [AXES];
    logic signed [CNT_W-1:0] r_cnt  [AXES];
    logic [AXES-1:0]         r_mov;

    logic                     axis_ok;
    logic [AXIS_IDX_W-1:0]    idx;
    logic [REPORT_W-1:0]      last;
    logic signed [CNT_W-1:0]  cnt;
    logic signed [CALC_W-1:0] v_sample;
    logic signed [CALC_W-1:0] v_last;
    logic signed [CALC_W-1:0] v_step;
    logic signed [CALC_W-1:0] v_dz;
    logic signed [CALC_W-1:0] diff;
    logic signed [CALC_W-1:0] mag;
    logic signed [CALC_W-1:0] cand;
    logic                     quiet;
    logic signed [CNT_W-1:0]  cnt_dec;
    logic signed [CNT_W-1:0]  cnt_inc;
    logic signed [CNT_W-1:0]  cnt_new;
    logic                     mov_new;
    logic                     cand_ok;
    logic [REPORT_W-1:0]      last_new;

    assign axis_ok = (int'(i_item.axis) < AXES);
    assign idx     = i_item.axis[AXIS_IDX_W-1:0];
    assign last    = r_last[idx];
    assign cnt     = r_cnt[idx];

    assign v_sample = signed'({{(CALC_W-SAMPLE_BITS){1'b0}}, i_item.sample});
    assign v_last   = signed'({{(CALC_W-REPORT_W){1'b0}}, last});
    assign v_step   = signed'({{(CALC_W-STEP_W){1'b0}}, i_cfg.max_step});
    assign v_dz     = signed'({{(CALC_W-DZ_W){1'b0}}, i_cfg.deadband});

    assign diff  = v_sample - v_last;
    assign mag   = diff[CALC_W-1] ? -diff : diff;
    assign quiet = mag < v_dz;

    // saturating activity counter
    assign cnt_dec = (cnt != CNT_MIN) ? cnt - CNT_W'(1) : cnt;
    assign cnt_inc = (cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;

    always_comb begin
        cnt_new = cnt_inc;
        mov_new = r_mov[idx];
        if (quiet) begin
            cnt_new = cnt_dec;
            if (cnt_dec <= i_cfg.static_threshold) begin
                cnt_new = '0;
                mov_new = 1'b0;
            end
        end else begin
            if (cnt_inc >= signed'({1'b0, i_cfg.active_threshold})) begin
                cnt_new = '0;
                mov_new = 1'b1;
            end
        end
    end

    // clamped step toward the sample
    always_comb begin
        priority if (diff > v_step) begin
            cand = v_last + v_step;
        end else if (diff < -v_step) begin
            cand = v_last - v_step;
        end else begin
            cand = v_sample;
        end
    end

    assign cand_ok  = !cand[CALC_W-1] &&
                      (cand <= signed'({{(CALC_W-REPORT_W){1'b0}}, REPORT_LIMIT}));
    assign last_new = (mov_new && cand_ok) ? cand[REPORT_W-1:0] : last;

    always_comb begin
        o_res.axis_out = i_item.axis;
        o_res.report   = axis_ok ? last_new : '0;
        o_res.moving   = axis_ok ? mov_new : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_last[i] <= CENTER_VALUE;
                r_cnt[i]  <= '0;
            end
            r_mov <= '0;
        end else if (i_fire && axis_ok) begin
            r_last[idx] <= last_new;
            r_cnt[idx]  <= cnt_new;
            r_mov[idx]  <= mov_new;
        end
    end

endmodule

// ===== sv/axis_activity_slew_limiter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_activity_slew_limiter_unit
// per-axis dead-zone activity detection and slew-limited reporting
// ----------------------------------------------------------------------------
// usage:
//   i_in   : one converter sample per transfer (axis index + sample)
//   o_out  : one result per sample (axis_out, report, moving), in order
//   i_cfg  : register writes (dead zone, static / active threshold, max step),
//            always ready; write only while the unit holds no item
// path: an accepted sample waits in the input register, then asl_cond
//   computes its result, which the result register offers at o_out
// throughput: one sample per cycle while o_out is not stalled; the
//   read-modify-write of the selected axis entry in asl_cond is combinational,
//   so back-to-back samples on the same axis see each other's update
// reset: synchronous, active low; every axis reports 2050, its activity
//   counter is zero and it is static; registers take their default values
// stall: while o_out.ready is low the result register holds, the input
//   register keeps one more sample, and i_in.ready drops after that
// ----------------------------------------------------------------------------
module axis_activity_slew_limiter_unit import asl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asl_in_if.sink    i_in,
    asl_out_if.source o_out,
    asl_cfg_if.sink   i_cfg
);

    t_cfg      cfg;
    t_in_item  in_item;
    t_in_item  s1_item;
    logic      s1_valid;
    logic      s1_fire;
    t_out_item res;

    logic      r_out_valid;
    t_out_item r_out;

    asl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .o_wr_ready (i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    assign in_item.axis   = i_in.axis;
    assign in_item.sample = i_in.sample;

    // the held sample moves on whenever the result register is free or drained
    assign s1_fire = s1_valid && (!r_out_valid || o_out.ready);

    asl_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_item    (in_item),
        .i_advance (s1_fire),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    // axis state update happens on the same edge the result is registered
    asl_cond u_cond (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (s1_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.axis_out = r_out.axis_out;
    assign o_out.report   = r_out.report;
    assign o_out.moving   = r_out.moving;

endmodule

// ===== sv/asl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_checker
// port-level checks of the slew limiter, bound to the top level
// ----------------------------------------------------------------------------
module asl_checker import asl_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    asl_in_if.sink    i_in,
    asl_out_if.source o_out,
    asl_cfg_if.sink   i_cfg
);

    // result stays offered while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=>
            $stable(o_out.report) && $stable(o_out.axis_out) && $stable(o_out.moving))
        else $error("result payload changed while stalled");

    // report never leaves its range
    a_report_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.report <= REPORT_LIMIT)
        else $error("report above limit");

    // a sample taken with an empty output is offered once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && !o_out.valid && !i_cfg.valid |-> ##2 o_out.valid)
        else $error("result missing after accepted sample");

endmodule

bind axis_activity_slew_limiter_unit asl_checker u_asl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .i_cfg   (i_cfg)
);
